[sv/rdsm_pkg.sv]
// ----------------------------------------------------------------------------
// rdsm_pkg
// Shared types and constants for the dot-star pattern matcher.
// ----------------------------------------------------------------------------
package rdsm_pkg;

  localparam int MAX_ELEMS_DEF = 8;
  localparam int CHAR_W        = 8;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_IDX_W     = 3;
  localparam int LEN_W         = 4;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_CHARS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_DOT_MASK  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_STAR_MASK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH    = 3'd3;

  typedef struct packed {
    logic [CFG_DATA_W-1:0]    chars;
    logic [MAX_ELEMS_DEF-1:0] dot_mask;
    logic [MAX_ELEMS_DEF-1:0] star_mask;
    logic [LEN_W-1:0]         length;
  } pattern_cfg_t;

  typedef struct packed {
    logic              has_char;
    logic [CHAR_W-1:0] text_char;
    logic              last_char;
  } text_item_t;

endpackage

[sv/rdsm_step.sv]
// ----------------------------------------------------------------------------
// rdsm_step
// One NFA step: advances the active position set by one character, if any, and
// closes it over skippable starred elements. Also gives the start closure.
// ----------------------------------------------------------------------------
module rdsm_step #(
  parameter int MAX_ELEMS = rdsm_pkg::MAX_ELEMS_DEF
) (
  input  rdsm_pkg::pattern_cfg_t  cfg,
  input  logic                    restart,
  input  logic [MAX_ELEMS:0]      set_in,
  input  rdsm_pkg::text_item_t    item,
  output logic [MAX_ELEMS:0]      set_out,
  output logic                    matched
);

  localparam int SW = MAX_ELEMS + 1;
  localparam int CW = $clog2(MAX_ELEMS + 1);

  logic [CW-1:0] count;
  logic [SW-1:0] start_set;
  logic [SW-1:0] cur_set;
  logic [SW-1:0] adv_set;

  function automatic logic [SW-1:0] close_set(
    input logic [SW-1:0]        s,
    input logic [MAX_ELEMS-1:0] star,
    input logic [CW-1:0]        n
  );
    logic [SW-1:0] r;
    r = s;
    for (int i = 0; i < MAX_ELEMS; i++) begin
      if ((CW'(i) < n) && r[i] && star[i]) begin
        r[i+1] = 1'b1;
      end
    end
    return r;
  endfunction

  always_comb begin
    if (cfg.length > rdsm_pkg::LEN_W'(MAX_ELEMS)) begin
      count = CW'(MAX_ELEMS);
    end else begin
      count = cfg.length[CW-1:0];
    end
  end

  assign start_set = close_set(SW'(1), cfg.star_mask[MAX_ELEMS-1:0], count);
  assign cur_set   = restart ? start_set : set_in;

  always_comb begin
    adv_set = '0;
    for (int i = 0; i < MAX_ELEMS; i++) begin
      if ((CW'(i) < count) && cur_set[i] &&
          (cfg.dot_mask[i] || (cfg.chars[8*i +: 8] == item.text_char))) begin
        if (cfg.star_mask[i]) begin
          adv_set[i] = 1'b1;
        end else begin
          adv_set[i+1] = 1'b1;
        end
      end
    end
  end

  assign set_out = item.has_char ?
                   close_set(adv_set, cfg.star_mask[MAX_ELEMS-1:0], count) : cur_set;
  assign matched = set_out[count];

endmodule

[sv/regex_dot_star_matcher_core.sv]
// ----------------------------------------------------------------------------
// regex_dot_star_matcher_core
// Whole-string matcher for patterns of literal or dot elements, each
// optionally starred, using a bit-parallel NFA over the pattern positions.
// ----------------------------------------------------------------------------
// One text byte per beat, one result beat per text beat, sustained rate one
// beat per cycle while result_stall is low. A beat is captured in an input
// register, the NFA step runs on it in shallow combinational logic (a byte
// compare per element plus a closure chain of at most MAX_ELEMS OR stages),
// and the verdict is loaded into a result register when the beat leaves the
// input register; a stalled verdict in the result register holds it there.
// The result register lets one new text beat be taken while a verdict waits
// downstream. A beat with last_char set closes the string; any write to a
// pattern register (cfg_index 0 to 3) restarts the current string.
module regex_dot_star_matcher_core #(
  parameter int MAX_ELEMS = rdsm_pkg::MAX_ELEMS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [rdsm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rdsm_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              text_valid,
  output logic                              text_stall,
  input  logic                              has_char,
  input  logic [rdsm_pkg::CHAR_W-1:0]       text_char,
  input  logic                              last_char,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic                              matched,
  output logic                              end_of_text
);

  rdsm_pkg::pattern_cfg_t cfg;
  rdsm_pkg::text_item_t   item;
  logic                   item_valid;
  logic [MAX_ELEMS:0]     active_set;
  logic [MAX_ELEMS:0]     active_set_next;
  logic                   restart;
  logic                   step_matched;
  logic                   result_open;
  logic                   text_take;
  logic                   item_move;

  assign result_open = !result_valid || !result_stall;
  assign item_move   = item_valid && result_open;
  assign text_stall  = item_valid && !result_open;
  assign text_take   = text_valid && !text_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        rdsm_pkg::REG_PATTERN_CHARS:     cfg.chars     <= cfg_data;
        rdsm_pkg::REG_PATTERN_DOT_MASK:  cfg.dot_mask  <= cfg_data[7:0];
        rdsm_pkg::REG_PATTERN_STAR_MASK: cfg.star_mask <= cfg_data[7:0];
        rdsm_pkg::REG_PATTERN_LENGTH:    cfg.length    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (text_take) begin
      item_valid <= 1'b1;
    end else if (item_move) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_take) begin
      item <= '{has_char: has_char, text_char: text_char, last_char: last_char};
    end
  end

  rdsm_step #(
    .MAX_ELEMS(MAX_ELEMS)
  ) u_step (
    .cfg     (cfg),
    .restart (restart),
    .set_in  (active_set),
    .item    (item),
    .set_out (active_set_next),
    .matched (step_matched)
  );

  // restart selects the start closure of the current pattern
  always_ff @(posedge clk) begin
    if (rst) begin
      restart <= 1'b1;
    end else if (cfg_write && (cfg_index <= rdsm_pkg::REG_PATTERN_LENGTH)) begin
      restart <= 1'b1;
    end else if (item_move) begin
      restart <= item.last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (item_move) begin
      active_set <= active_set_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_open) begin
      result_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_move) begin
      matched     <= step_matched;
      end_of_text <= item.last_char;
    end
  end

endmodule

[sv/rdsm_checker.sv]
// ----------------------------------------------------------------------------
// rdsm_checker
// Port-level checks for the matcher core, bound into the core module.
// ----------------------------------------------------------------------------
module rdsm_checker (
  input logic clk,
  input logic rst,
  input logic text_valid,
  input logic text_stall,
  input logic result_valid,
  input logic result_stall,
  input logic matched,
  input logic end_of_text
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(matched) && $stable(end_of_text))
    else $error("stalled result beat changed");

  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    text_stall |-> result_valid && result_stall)
    else $error("text stalled while result side open");

  a_result_from_text: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(text_valid && !text_stall, 2))
    else $error("result beat without a text beat two cycles earlier");

endmodule

bind regex_dot_star_matcher_core rdsm_checker u_rdsm_checker (
  .clk          (clk),
  .rst          (rst),
  .text_valid   (text_valid),
  .text_stall   (text_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .matched      (matched),
  .end_of_text  (end_of_text)
);
